// ===== sv/edf_pkg.sv =====
// shared types and constants for the edf task selector
`default_nettype none
package edf_pkg;
   localparam int TASK_COUNT = 8;
   localparam int TIME_BITS  = 48;
   localparam int IDX_BITS   = 3;

   typedef enum logic [1:0] {
      KIND_DEADLINE = 2'd0,
      KIND_FAST     = 2'd1,
      KIND_SLOW     = 2'd2,
      KIND_SELECT   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  task_index;
      logic [47:0] load_value;
      logic [7:0]  alive_mask;
      logic [47:0] now_us;
      logic [47:0] idle_us;
   } req_type;

   typedef struct packed {
      logic        task_valid;
      logic [2:0]  chosen_task;
      logic        run_fast;
      logic [47:0] idle_total;
      logic [47:0] low_freq_total;
      logic [47:0] high_freq_total;
   } rsp_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SEL_RD,
      ST_SEL_ORD,
      ST_SEL_TAB,
      ST_SEL_DIV,
      ST_SEL_CHK,
      ST_DONE
   } state_type;

   // request to the divider
   typedef struct packed {
      logic                 start;
      logic [TIME_BITS-1:0] dividend;
      logic [TIME_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [TIME_BITS-1:0] remainder;
   } div_rsp_type;
endpackage
`default_nettype wire

// ===== sv/edf_task_select_with_dvfs.sv =====
// Earliest-deadline-first task selector with high/low frequency request.
// Channels: req_ (valid/ready, req_type payload) takes load and select
// transactions; rsp_ (valid/ready, rsp_type payload) returns one result per
// select, none per load.
// Tables (deadline, fast, slow, order) live in synchronous rams with a
// registered read; a sequencer reads, modifies and writes them back.
// One transaction at a time. A fast/slow load is written straight from
// idle, so loads can follow each other every cycle. A deadline load
// re-sorts the order by rank counting. A select walks up to 8 tasks; for
// each task it reads the order ram, then the tables, then runs the
// bit-serial remainder unit; ST_DONE then fills the result register.
// After reset a clearing pass over all 8 entries zeroes the tables and
// loads the identity order; req_ready is low during it.
// A result sits in an output register; while rsp_ready is low the block
// still takes new load transactions, and takes a select only once the
// output register is free.
`default_nettype none
module edf_task_select_with_dvfs
   import edf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);
   localparam int TB = TIME_BITS;
   localparam int IB = IDX_BITS;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [IB:0] i_ff, i_in;        // outer counter (wide enough to hold count)
   logic [IB:0] j_ff, j_in;
   logic [IB:0] rank_ff, rank_in;
   logic [TB-1:0] dcur_ff, dcur_in;
   logic [TB:0] pred_ff, pred_in;   // extra bit flags sum overflow
   logic over_ff, over_in;
   logic picked_ff, picked_in;
   logic [IB-1:0] chosen_ff, chosen_in;
   logic fast_ff, fast_in;
   logic [IB-1:0] t_ff, t_in;
   logic [TB-1:0] d_ff, d_in;
   logic [TB-1:0] add_ff, add_in;
   logic [TB-1:0] idle_ff, idle_in, low_ff, low_in, high_ff, high_in;
   logic [TB-1:0] last_t_ff, last_t_in;
   logic last_f_ff, last_f_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;

   // ram ports
   logic dl_we, fa_we, sl_we, or_we;
   logic [IB-1:0] dl_wa, fa_wa, sl_wa, or_wa;
   logic [TB-1:0] dl_wd, fa_wd, sl_wd;
   logic [IB-1:0] or_wd;
   logic [IB-1:0] dl_ra, tab_ra, or_ra;
   logic [TB-1:0] dl_rd, fa_rd, sl_rd;
   logic [IB-1:0] or_rd;

   div_req_type div_req;
   div_rsp_type div_rsp;

   edf_ram #(.WIDTH(TB), .DEPTH(TASK_COUNT)) u_dl (.clock, .wr_en(dl_we),
      .wr_addr(dl_wa), .wr_data(dl_wd), .rd_addr(dl_ra), .rd_data(dl_rd));
   edf_ram #(.WIDTH(TB), .DEPTH(TASK_COUNT)) u_fa (.clock, .wr_en(fa_we),
      .wr_addr(fa_wa), .wr_data(fa_wd), .rd_addr(tab_ra), .rd_data(fa_rd));
   edf_ram #(.WIDTH(TB), .DEPTH(TASK_COUNT)) u_sl (.clock, .wr_en(sl_we),
      .wr_addr(sl_wa), .wr_data(sl_wd), .rd_addr(tab_ra), .rd_data(sl_rd));
   edf_ram #(.WIDTH(IB), .DEPTH(TASK_COUNT)) u_or (.clock, .wr_en(or_we),
      .wr_addr(or_wa), .wr_data(or_wd), .rd_addr(or_ra), .rd_data(or_rd));

   edf_mod u_mod (.clock, .reset, .div_req, .div_rsp);

   logic [TB:0]   sum;
   logic [TB:0]   lim;
   logic [TB-1:0] delta;
   logic          hit;
   logic          this_pick;

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      rank_in   = rank_ff;
      dcur_in   = dcur_ff;
      pred_in   = pred_ff;
      over_in   = over_ff;
      picked_in = picked_ff;
      chosen_in = chosen_ff;
      fast_in   = fast_ff;
      t_in      = t_ff;
      d_in      = d_ff;
      add_in    = add_ff;
      idle_in   = idle_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      last_t_in = last_t_ff;
      last_f_in = last_f_ff;
      rv_in     = rv_ff;
      rsp_in    = rsp_ff;
      req_ready = 1'b0;
      dl_we = 1'b0; fa_we = 1'b0; sl_we = 1'b0; or_we = 1'b0;
      dl_wa = req_ff.task_index; fa_wa = req_ff.task_index;
      sl_wa = req_ff.task_index; or_wa = rank_ff[IB-1:0];
      dl_wd = req_ff.load_value; fa_wd = req_ff.load_value;
      sl_wd = req_ff.load_value; or_wd = i_ff[IB-1:0];
      dl_ra = i_ff[IB-1:0];
      tab_ra = t_ff;
      or_ra = i_ff[IB-1:0];
      div_req.start    = 1'b0;
      div_req.dividend = req_ff.now_us;
      div_req.divisor  = d_ff;
      this_pick = 1'b0;
      sum   = pred_ff + {1'b0, add_ff};
      lim   = {1'b0, d_ff - div_rsp.remainder};
      hit   = 1'b0;
      delta = req_ff.now_us - last_t_ff;

      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            dl_we = 1'b1; fa_we = 1'b1; sl_we = 1'b1; or_we = 1'b1;
            dl_wa = i_ff[IB-1:0]; fa_wa = i_ff[IB-1:0];
            sl_wa = i_ff[IB-1:0]; or_wa = i_ff[IB-1:0];
            dl_wd = '0; fa_wd = '0; sl_wd = '0; or_wd = i_ff[IB-1:0];
            i_in = i_ff + 1'b1;
            if (i_ff == (IB+1)'(TASK_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = !(req_data.kind == KIND_SELECT && rv_ff && !rsp_ready);
            if (req_valid && req_ready) begin
               req_in = req_data;
               i_in   = '0;
               case (kind_type'(req_data.kind))
                  KIND_DEADLINE: begin
                     dl_we = 1'b1;
                     dl_wa = req_data.task_index;
                     dl_wd = req_data.load_value;
                     state_in = ST_SORT_RD;
                  end
                  KIND_FAST: begin
                     fa_we = 1'b1;
                     fa_wa = req_data.task_index;
                  end
                  KIND_SLOW: begin
                     sl_we = 1'b1;
                     sl_wa = req_data.task_index;
                  end
                  KIND_SELECT: begin
                     pred_in = '0; over_in = 1'b0; picked_in = 1'b0;
                     chosen_in = '0; fast_in = 1'b0;
                     state_in = ST_SEL_RD;
                  end
                  default: ;
               endcase
               fa_wd = req_data.load_value;
               sl_wd = req_data.load_value;
            end
         end
         // rank of task i = count of tasks j ordered before it
         ST_SORT_RD: begin
            dl_ra = i_ff[IB-1:0];
            j_in = '0;
            rank_in = '0;
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            if (j_ff == '0) begin
               dcur_in = dl_rd;  // first cycle: dl_rd holds deadline of i
            end else begin
               if (dl_rd < dcur_ff ||
                   (dl_rd == dcur_ff && (j_ff - 1'b1) < i_ff)) begin
                  rank_in = rank_ff + 1'b1;
               end
            end
            dl_ra = j_ff[IB-1:0];
            if (j_ff == (IB+1)'(TASK_COUNT)) begin
               or_we = 1'b1;
               or_wa = rank_in[IB-1:0];
               or_wd = i_ff[IB-1:0];
               i_in  = i_ff + 1'b1;
               state_in = (i_ff == (IB+1)'(TASK_COUNT - 1)) ? ST_IDLE : ST_SORT_RD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_SEL_RD: begin
            or_ra = i_ff[IB-1:0];
            state_in = ST_SEL_ORD;
         end
         ST_SEL_ORD: begin
            t_in = or_rd;
            state_in = ST_SEL_TAB;
         end
         ST_SEL_TAB: begin
            tab_ra = t_ff;
            dl_ra  = t_ff;
            state_in = ST_SEL_DIV;
         end
         ST_SEL_DIV: begin
            this_pick = !picked_ff && req_ff.alive_mask[t_ff];
            if (this_pick) begin
               picked_in = 1'b1;
               chosen_in = t_ff;
            end
            add_in = this_pick ? sl_rd : fa_rd;
            d_in   = dl_rd;
            div_req.start   = 1'b1;
            div_req.divisor = dl_rd;
            state_in = ST_SEL_CHK;
         end
         ST_SEL_CHK: begin
            if (div_rsp.done) begin
               pred_in = sum[TB] ? pred_ff : sum;
               if (sum[TB] || pred_ff[TB]) begin
                  over_in = 1'b1;
                  pred_in[TB] = 1'b1;
               end
               hit = (d_ff != '0) && (over_in || sum > lim);
               if (hit) begin
                  fast_in = 1'b1;
               end
               i_in = i_ff + 1'b1;
               if ((hit && picked_ff) || i_ff == (IB+1)'(TASK_COUNT - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SEL_RD;
               end
            end
         end
         ST_DONE: begin
            if (!rv_ff || rsp_ready) begin
               idle_in = idle_ff + req_ff.idle_us;
               if (last_f_ff) begin
                  high_in = high_ff + delta;
               end else begin
                  low_in = low_ff + delta;
               end
               last_t_in = req_ff.now_us;
               last_f_in = fast_ff;
               rv_in = 1'b1;
               rsp_in.task_valid      = picked_ff;
               rsp_in.chosen_task     = picked_ff ? chosen_ff : '0;
               rsp_in.run_fast        = fast_ff;
               rsp_in.idle_total      = idle_in;
               rsp_in.low_freq_total  = low_in;
               rsp_in.high_freq_total = high_in;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         i_ff      <= '0;
         rv_ff     <= 1'b0;
         idle_ff   <= '0;
         low_ff    <= '0;
         high_ff   <= '0;
         last_t_ff <= '0;
         last_f_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         i_ff      <= i_in;
         rv_ff     <= rv_in;
         idle_ff   <= idle_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         last_t_ff <= last_t_in;
         last_f_ff <= last_f_in;
      end
      req_ff    <= req_in;
      j_ff      <= j_in;
      rank_ff   <= rank_in;
      dcur_ff   <= dcur_in;
      pred_ff   <= pred_in;
      over_ff   <= over_in;
      picked_ff <= picked_in;
      chosen_ff <= chosen_in;
      fast_ff   <= fast_in;
      t_ff      <= t_in;
      d_ff      <= d_in;
      add_ff    <= add_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("ready outside idle");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result not from done");
   a_chosen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.task_valid) |-> (rsp_data.chosen_task == '0))
      else $error("chosen task without pick");
`endif
endmodule
`default_nettype wire

// ===== sv/edf_ram.sv =====
// generic single-port-write, single-read ram with registered read
`default_nettype none
module edf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== sv/edf_mod.sv =====
// bit-serial remainder unit, one quotient bit per cycle
`default_nettype none
module edf_mod
   import edf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output      div_rsp_type div_rsp
);
   localparam int CNT_BITS = $clog2(TIME_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [TIME_BITS-1:0] num_ff, num_in;
   logic [TIME_BITS-1:0] den_ff, den_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS:0]   shifted;
   logic [TIME_BITS:0]   diff;

   always_comb begin
      shifted = {rem_ff, num_ff[TIME_BITS-1]};
      diff    = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(TIME_BITS);
         num_in  = div_req.dividend;
         den_in  = div_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[TIME_BITS-2:0], 1'b0};
         rem_in = diff[TIME_BITS] ? shifted[TIME_BITS-1:0] : diff[TIME_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef ASSERT_OFF
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |=> !div_rsp.done)
      else $error("remainder done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> $past(busy_ff))
      else $error("done without busy");
   // a zero divisor gives no meaningful remainder
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (div_rsp.done && den_ff != '0) |-> (rem_ff < den_ff))
      else $error("remainder not reduced");
`endif
endmodule
`default_nettype wire
